// ===== src/dq_pkg.sv =====
// Shared types and constants for the double-ended queue core.
// Used by the request/response interfaces, the storage cells, the cell chain and the top level.
package dq_pkg;

  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [OCC_W-1:0]         occ_t;

  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_BACK  = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_POP_BACK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD        = 3'd0,
    CMD_INSERT_HEAD = 3'd1,
    CMD_REMOVE_HEAD = 3'd2,
    CMD_APPEND_TAIL = 3'd3,
    CMD_DROP_TAIL   = 3'd4
  } cmd_t;

endpackage

// ===== src/dq_if.sv =====
// Valid/ready channel interfaces for requests and responses of the queue core.
// Depends on dq_pkg for the payload types.
interface dq_req_if;
  import dq_pkg::*;
  logic  valid;
  logic  ready;
  func_t func;
  word_t push_value;

  modport source (output valid, func, push_value, input ready);
  modport sink (input valid, func, push_value, output ready);
endinterface

interface dq_rsp_if;
  import dq_pkg::*;
  logic    valid;
  logic    ready;
  word_t   pop_value;
  status_t status;
  occ_t    occupancy;

  modport source (output valid, pop_value, status, occupancy, input ready);
  modport sink (input valid, pop_value, status, occupancy, output ready);
endinterface

// ===== src/dq_cell.sv =====
// One storage cell of the queue chain: a word and its occupied flag.
// Depends on dq_pkg for the command and word types.
module dq_cell (
  input  logic          clk,
  input  logic          rst,
  input  dq_pkg::cmd_t  cmd,
  input  dq_pkg::word_t push_value,
  input  dq_pkg::word_t left_data,
  input  logic          left_valid,
  input  dq_pkg::word_t right_data,
  input  logic          right_valid,
  output dq_pkg::word_t data,
  output logic          valid
);
  import dq_pkg::*;

  logic is_slot;
  logic is_tail;

  // The first free cell takes an appended word; the last used cell is the tail.
  assign is_slot = !valid && left_valid;
  assign is_tail = valid && !right_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd)
        CMD_INSERT_HEAD: valid <= left_valid;
        CMD_REMOVE_HEAD: valid <= right_valid;
        CMD_APPEND_TAIL: if (is_slot) valid <= 1'b1;
        CMD_DROP_TAIL:   if (is_tail) valid <= 1'b0;
        default:         valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_INSERT_HEAD: data <= left_data;
      CMD_REMOVE_HEAD: data <= right_data;
      CMD_APPEND_TAIL: if (is_slot) data <= push_value;
      default:         data <= data;
    endcase
  end

endmodule

// ===== src/dq_chain.sv =====
// A row of queue cells whose head sits at the first cell and whose words stay packed.
// Depends on dq_pkg and dq_cell.
module dq_chain #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  dq_pkg::cmd_t     cmd,
  input  dq_pkg::word_t    push_value,
  output dq_pkg::word_t    head_data,
  output logic [DEPTH-1:0] occupied
);
  import dq_pkg::*;

  word_t data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_data;
    word_t right_data;
    logic  left_valid;
    logic  right_valid;

    if (i == 0) begin : g_first
      assign left_data  = push_value;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_data  = data[i-1];
      assign left_valid = occupied[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_data  = data[i+1];
      assign right_valid = occupied[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .push_value  (push_value),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (data[i]),
      .valid       (occupied[i])
    );
  end

  assign head_data = data[0];

endmodule

// ===== src/double_ended_queue_core.sv =====
// Bounded double-ended queue of signed 32-bit words, DEPTH entries deep. Every request
// (push front, push back, pop front, pop back) gives one response in the cycle after it is
// accepted, and a new request is taken in every cycle while the response register is free
// or being drained. The words live in two chains of DEPTH cells: one keeps the front word
// in its first cell, the other keeps the words in reverse order with the back word in its
// first cell, so every operation is a shift, append or drop in both chains.
// Both pops read a fixed cell. Reset clears valid flags and count, never data; no clearing pass.
// Depends on dq_pkg, dq_if, dq_cell and dq_chain.
module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input logic     clk,
  input logic     rst,
  dq_req_if.sink  req,
  dq_rsp_if.source rsp
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW+4:0]    occ_wide;
  logic             fire;
  logic             full;
  logic             empty;
  cmd_t             cmd_front;
  cmd_t             cmd_back;
  word_t            front_head;
  word_t            back_head;
  word_t            pop_next;
  status_t          status_next;
  logic [DEPTH-1:0] front_occupied;
  logic [DEPTH-1:0] back_occupied;

  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    cmd_front   = CMD_HOLD;
    cmd_back    = CMD_HOLD;
    pop_next    = '0;
    status_next = ST_OK;
    count_next  = count;
    unique case (req.func)
      FN_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd_front  = CMD_INSERT_HEAD;
          cmd_back   = CMD_APPEND_TAIL;
          count_next = count + CW'(1);
        end
      end
      FN_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd_front  = CMD_APPEND_TAIL;
          cmd_back   = CMD_INSERT_HEAD;
          count_next = count + CW'(1);
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd_front  = CMD_REMOVE_HEAD;
          cmd_back   = CMD_DROP_TAIL;
          pop_next   = front_head;
          count_next = count - CW'(1);
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd_front  = CMD_DROP_TAIL;
          cmd_back   = CMD_REMOVE_HEAD;
          pop_next   = back_head;
          count_next = count - CW'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    if (!fire) begin
      cmd_front  = CMD_HOLD;
      cmd_back   = CMD_HOLD;
      count_next = count;
    end
  end

  assign occ_wide = (CW + 5)'(count_next);

  dq_chain #(.DEPTH(DEPTH)) u_front_chain (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_front),
    .push_value (req.push_value),
    .head_data  (front_head),
    .occupied   (front_occupied)
  );

  dq_chain #(.DEPTH(DEPTH)) u_back_chain (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_back),
    .push_value (req.push_value),
    .head_data  (back_head),
    .occupied   (back_occupied)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.pop_value <= pop_next;
      rsp.status    <= status_next;
      rsp.occupancy <= occ_wide[4:0];
    end
  end

  // Both chains must hold exactly as many words as the counter says.
  a_front_count: assert property (@(posedge clk) disable iff (rst)
    $countones(front_occupied) == count)
    else $error("front chain occupancy differs from count");

  a_back_count: assert property (@(posedge clk) disable iff (rst)
    $countones(back_occupied) == count)
    else $error("back chain occupancy differs from count");

  // With a single word stored, front and back are the same word.
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    count == CW'(1) |-> front_head == back_head)
    else $error("front and back heads disagree with one word stored");

  // A rejected push or pop leaves the occupancy unchanged.
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    fire && (status_next == ST_FULL || status_next == ST_EMPTY) |=> count == $past(count))
    else $error("rejected request changed the occupancy");

endmodule

// ===== test/deque_checker.sv =====
`timescale 1ns / 100ps
// Checker for the double-ended queue core: it watches the request and response channels,
// keeps its own ring model of the queue, and compares every response with the prediction.
// Depends on dq_pkg and the dq_req_if / dq_rsp_if interfaces.
module deque_checker #(
  parameter int DEPTH = 16
) (
  input logic clk,
  input logic rst,
  dq_req_if   req,
  dq_rsp_if   rsp,
  output int  fail_count,
  output int  pending
);
  import dq_pkg::*;

  typedef struct packed {
    word_t   pop_value;
    status_t status;
    occ_t    occupancy;
  } deque_result_t;

  word_t         slots [DEPTH];
  int unsigned   head_idx;
  int unsigned   tail_idx;
  int unsigned   count;
  deque_result_t owed_results [$];
  int            mismatches = 0;
  int            waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  function automatic deque_result_t apply_request(func_t f, word_t v);
    deque_result_t r;
    r.pop_value = '0;
    r.status    = ST_OK;
    case (f)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (f == FN_PUSH_FRONT) begin
          head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
          slots[head_idx] = v;
          count++;
        end else begin
          slots[tail_idx] = v;
          tail_idx = (tail_idx + 1 == DEPTH) ? 0 : tail_idx + 1;
          count++;
        end
      end
      default: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else if (f == FN_POP_FRONT) begin
          r.pop_value = slots[head_idx];
          head_idx = (head_idx + 1 == DEPTH) ? 0 : head_idx + 1;
          count--;
        end else begin
          tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
          r.pop_value = slots[tail_idx];
          count--;
        end
      end
    endcase
    r.occupancy = occ_t'(count);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t deque_checker: %s: got %0h, expected %0h", $realtime, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      head_idx = 0;
      tail_idx = 0;
      count    = 0;
      owed_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        owed_results.push_back(apply_request(req.func, req.push_value));
      end
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          report("response with no request outstanding", rsp.pop_value, '0);
        end else begin
          want = owed_results.pop_front();
          if (rsp.pop_value !== want.pop_value) begin
            report("pop_value", rsp.pop_value, want.pop_value);
          end
          if (rsp.status !== want.status) begin
            report("status", rsp.status, want.status);
          end
          if (rsp.occupancy !== want.occupancy) begin
            report("occupancy", rsp.occupancy, want.occupancy);
          end
        end
      end
    end
    waiting <= owed_results.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Top of the double-ended queue testbench: clock, reset, request stimulus, response stalls
// and the verdict. Depends on dq_pkg, the dq interfaces, double_ended_queue_core and deque_checker.
module tb;
  import dq_pkg::*;

  localparam int DEPTH = 16;

  logic clk = 1'b0;
  logic rst;
  bit   rush;
  int   fail_count;
  int   pending;

  dq_req_if req ();
  dq_rsp_if rsp ();

  double_ended_queue_core #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  deque_checker #(.DEPTH(DEPTH)) watch (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send(func_t f, word_t v);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.func       <= f;
    req.push_value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic func_t pick_request(int push_pct);
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
  endfunction

  initial begin
    int stall;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rush ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  initial begin
    int push_pct;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.func       <= FN_PUSH_FRONT;
    req.push_value <= '0;
    rush = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Pops on an empty queue, the extreme words through both ends, fill to full, then push on full and pop.
    send(FN_POP_FRONT, word_t'($urandom));
    send(FN_POP_BACK, word_t'($urandom));
    send(FN_PUSH_FRONT, 32'sh7fffffff);
    send(FN_PUSH_BACK, 32'sh80000000);
    send(FN_POP_FRONT, word_t'($urandom));
    send(FN_POP_BACK, word_t'($urandom));
    for (int i = 0; i < DEPTH; i++) begin
      send(i[0] ? FN_PUSH_BACK : FN_PUSH_FRONT,
           (i == 0) ? word_t'(0) : (i == 1) ? word_t'(-1) : word_t'($urandom));
    end
    send(FN_PUSH_FRONT, word_t'($urandom));
    send(FN_PUSH_BACK, word_t'($urandom));
    send(FN_POP_FRONT, word_t'($urandom));
    send(FN_POP_BACK, word_t'($urandom));
    drain();

    push_pct = 50;
    for (int n = 0; n < 1300; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 80;
          default: push_pct = 95;
        endcase
        rush = ($urandom_range(0, 3) == 0);
      end
      if (n % 300 == 299) begin
        drain();
      end
      send(pick_request(push_pct), word_t'($urandom));
    end
    req.valid <= 1'b0;
    rush = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
